FILE: rtl/sng_pkg.sv
// ----------------------------------------------------------------------------
// Square and noise sound generator package
// Widths, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package sng_pkg;

    localparam int TICK_DIVIDE   = 8;
    localparam int PRESCALE_W    = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;

    localparam int TONE_PERIOD_W = 10;
    localparam int TONE_COUNT_W  = 11;
    localparam int NOISE_COUNT_W = 12;
    localparam int NOISE_SHIFT_W = 15;
    localparam int ATTEN_W       = 4;
    localparam int NUM_TONES     = 3;

    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 15;

    localparam logic [NOISE_COUNT_W-1:0] DIV_SLOW0_RESET = 12'd16;
    localparam logic [NOISE_COUNT_W-1:0] DIV_MID1_RESET  = 12'd32;
    localparam logic [NOISE_COUNT_W-1:0] DIV_FAST2_RESET = 12'd64;
    localparam logic [NOISE_SHIFT_W-1:0] SEED_RESET      = 15'd16384;
    localparam logic [ATTEN_W-1:0]       ATTEN_SILENT    = 4'd15;

    typedef enum logic [2:0] {
        SEL_TONE0_FREQ  = 3'd0,
        SEL_TONE0_ATTEN = 3'd1,
        SEL_TONE1_FREQ  = 3'd2,
        SEL_TONE1_ATTEN = 3'd3,
        SEL_TONE2_FREQ  = 3'd4,
        SEL_TONE2_ATTEN = 3'd5,
        SEL_NOISE_CTRL  = 3'd6,
        SEL_NOISE_ATTEN = 3'd7
    } t_select;

    typedef enum logic [1:0] {
        RATE_SLOW0 = 2'd0,
        RATE_MID1  = 2'd1,
        RATE_FAST2 = 2'd2,
        RATE_TONE2 = 2'd3
    } t_rate;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIV_SLOW0 = 2'd0,
        CFG_DIV_MID1  = 2'd1,
        CFG_DIV_FAST2 = 2'd2,
        CFG_SEED      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [NOISE_COUNT_W-1:0] div_fast2;
        logic [NOISE_COUNT_W-1:0] div_mid1;
        logic [NOISE_COUNT_W-1:0] div_slow0;
        logic [NOISE_SHIFT_W-1:0] seed;
    } t_cfg;

    // packed MSB first: tone0_bit ends up in bit 0
    typedef struct packed {
        logic [NOISE_SHIFT_W-1:0] noise_register;
        logic [ATTEN_W-1:0]       noise_atten;
        logic [ATTEN_W-1:0]       tone2_atten;
        logic [ATTEN_W-1:0]       tone1_atten;
        logic [ATTEN_W-1:0]       tone0_atten;
        logic                     noise_bit;
        logic                     tone2_bit;
        logic                     tone1_bit;
        logic                     tone0_bit;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // period of zero counts as 1024
    function automatic logic [TONE_COUNT_W-1:0] full_period(
        input logic [TONE_PERIOD_W-1:0] period
    );
        logic [TONE_COUNT_W-1:0] result;
        if (period == '0) begin
            result = TONE_COUNT_W'(1024);
        end else begin
            result = {1'b0, period};
        end
        return result;
    endfunction

endpackage

FILE: rtl/sng_core.sv
// ----------------------------------------------------------------------------
// Sound generator core
// Register file, prescaler, tone counters and noise shift register; gives
// the result of each request from the state it leaves.
// ----------------------------------------------------------------------------
module sng_core
    import sng_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_kind,
    input  logic [7:0] i_data,
    input  t_cfg       i_cfg,
    output logic       o_updated,
    output t_result    o_result
);

    logic [TONE_PERIOD_W-1:0] r_period [NUM_TONES];
    logic [TONE_COUNT_W-1:0]  r_count  [NUM_TONES];
    logic [NUM_TONES-1:0]     r_flip;
    logic [ATTEN_W-1:0]       r_volume [NUM_TONES];
    t_rate                    r_noise_rate;
    logic                     r_noise_white;
    logic [NOISE_SHIFT_W-1:0] r_noise_shift;
    logic [NOISE_COUNT_W-1:0] r_noise_count;
    logic                     r_noise_flip;
    logic [ATTEN_W-1:0]       r_noise_volume;
    t_select                  r_latched;
    logic [PRESCALE_W-1:0]    r_prescale;

    logic [TONE_PERIOD_W-1:0] n_period [NUM_TONES];
    logic [TONE_COUNT_W-1:0]  n_count  [NUM_TONES];
    logic [NUM_TONES-1:0]     n_flip;
    logic [ATTEN_W-1:0]       n_volume [NUM_TONES];
    t_rate                    n_noise_rate;
    logic                     n_noise_white;
    logic [NOISE_SHIFT_W-1:0] n_noise_shift;
    logic [NOISE_COUNT_W-1:0] n_noise_count;
    logic                     n_noise_flip;
    logic [ATTEN_W-1:0]       n_noise_volume;
    t_select                  n_latched;
    logic [PRESCALE_W-1:0]    n_prescale;
    logic                     n_updated;

    t_select                  w_sel;
    t_rate                    w_rate;
    logic [NOISE_COUNT_W-1:0] w_noise_reload;

    assign w_sel  = t_select'(i_data[6:4]);
    assign w_rate = t_rate'(i_data[1:0]);

    always_comb begin
        case (r_noise_rate)
            RATE_SLOW0: w_noise_reload = i_cfg.div_slow0;
            RATE_MID1:  w_noise_reload = i_cfg.div_mid1;
            RATE_FAST2: w_noise_reload = i_cfg.div_fast2;
            default:    w_noise_reload = {full_period(r_period[2]), 1'b0};
        endcase
    end

    always_comb begin
        n_period       = r_period;
        n_count        = r_count;
        n_flip         = r_flip;
        n_volume       = r_volume;
        n_noise_rate   = r_noise_rate;
        n_noise_white  = r_noise_white;
        n_noise_shift  = r_noise_shift;
        n_noise_count  = r_noise_count;
        n_noise_flip   = r_noise_flip;
        n_noise_volume = r_noise_volume;
        n_latched      = r_latched;
        n_prescale     = r_prescale;
        n_updated      = 1'b0;

        if (!i_kind) begin
            if (i_data[7]) begin
                n_latched = w_sel;
                case (w_sel)
                    SEL_NOISE_CTRL: begin
                        n_noise_rate  = w_rate;
                        n_noise_white = i_data[2];
                        n_noise_shift = i_cfg.seed;
                        case (w_rate)
                            RATE_SLOW0: n_noise_count = i_cfg.div_slow0;
                            RATE_MID1:  n_noise_count = i_cfg.div_mid1;
                            RATE_FAST2: n_noise_count = i_cfg.div_fast2;
                            default:    n_noise_count = r_noise_count;
                        endcase
                    end
                    SEL_NOISE_ATTEN: begin
                        n_noise_volume = i_data[3:0];
                    end
                    default: begin
                        for (int i = 0; i < NUM_TONES; i++) begin
                            if (w_sel[2:1] == 2'(i)) begin
                                if (w_sel[0]) begin
                                    n_volume[i] = i_data[3:0];
                                end else begin
                                    n_period[i] = {r_period[i][9:4], i_data[3:0]};
                                end
                            end
                        end
                    end
                endcase
            end else begin
                for (int i = 0; i < NUM_TONES; i++) begin
                    if (!r_latched[0] && r_latched[2:1] == 2'(i)) begin
                        n_period[i] = {i_data[5:0], r_period[i][3:0]};
                    end
                end
            end
        end else if (r_prescale == PRESCALE_W'(TICK_DIVIDE - 1)) begin
            n_prescale = '0;
            n_updated  = 1'b1;
            for (int i = 0; i < NUM_TONES; i++) begin
                if (r_count[i] != '0) begin
                    n_count[i] = r_count[i] - 1'b1;
                end else begin
                    n_flip[i]  = ~r_flip[i];
                    n_count[i] = full_period(r_period[i]);
                end
            end
            if (r_noise_count != '0) begin
                n_noise_count = r_noise_count - 1'b1;
            end else begin
                if (r_noise_white) begin
                    n_noise_shift = {r_noise_shift[0] ^ r_noise_shift[1],
                                     r_noise_shift[NOISE_SHIFT_W-1:1]};
                    n_noise_flip  = r_noise_shift[1];
                end else begin
                    n_noise_shift = {r_noise_shift[0], r_noise_shift[NOISE_SHIFT_W-1:1]};
                    n_noise_flip  = r_noise_shift[0];
                end
                n_noise_count = w_noise_reload;
            end
        end else begin
            n_prescale = r_prescale + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TONES; i++) begin
                r_period[i] <= '0;
                r_count[i]  <= '0;
                r_volume[i] <= ATTEN_SILENT;
            end
            r_flip         <= '0;
            r_noise_rate   <= RATE_SLOW0;
            r_noise_white  <= 1'b1;
            r_noise_shift  <= SEED_RESET;
            r_noise_count  <= DIV_SLOW0_RESET;
            r_noise_flip   <= 1'b0;
            r_noise_volume <= ATTEN_SILENT;
            r_latched      <= SEL_TONE0_FREQ;
            r_prescale     <= '0;
        end else if (i_accept) begin
            r_period       <= n_period;
            r_count        <= n_count;
            r_flip         <= n_flip;
            r_volume       <= n_volume;
            r_noise_rate   <= n_noise_rate;
            r_noise_white  <= n_noise_white;
            r_noise_shift  <= n_noise_shift;
            r_noise_count  <= n_noise_count;
            r_noise_flip   <= n_noise_flip;
            r_noise_volume <= n_noise_volume;
            r_latched      <= n_latched;
            r_prescale     <= n_prescale;
        end
    end

    assign o_updated = n_updated;

    always_comb begin
        o_result.tone0_bit      = n_flip[0];
        o_result.tone1_bit      = n_flip[1];
        o_result.tone2_bit      = n_flip[2];
        o_result.noise_bit      = n_noise_flip;
        o_result.tone0_atten    = n_volume[0];
        o_result.tone1_atten    = n_volume[1];
        o_result.tone2_atten    = n_volume[2];
        o_result.noise_atten    = n_noise_volume;
        o_result.noise_register = n_noise_shift;
    end

endmodule

FILE: rtl/square_and_noise_sound_generator.sv
// ----------------------------------------------------------------------------
// Square and noise sound generator
// Three tone channels and one noise channel, programmed by bus byte writes
// and advanced by clock tick requests.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle unless the output register is stalled,
// and its result appears there on the following cycle; the state update and the
// result are formed in a single pass through the generator core. Bus write
// requests carry s_axis_tuser = 0, tick requests s_axis_tuser = 1; every eighth
// tick runs a generator update, flagged by m_axis_tuser. Configuration writes
// are taken at any time and should be made while no request is outstanding.
module square_and_noise_sound_generator
    import sng_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data
    input  logic                   s_axis_tuser,   // [0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] tone0_bit, [1] tone1_bit, [2] tone2_bit, [3] noise_bit,
    // [7:4] tone0_atten, [11:8] tone1_atten, [15:12] tone2_atten,
    // [19:16] noise_atten, [34:20] noise_register, [39:35] zero
    output logic [TDATA_W-1:0]     m_axis_tdata,
    output logic                   m_axis_tuser,   // [0] updated
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_m_valid;
    logic               r_m_user;
    logic [TDATA_W-1:0] r_m_data;

    logic    w_accept;
    logic    w_updated;
    t_result w_result;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.div_slow0 <= DIV_SLOW0_RESET;
            r_cfg.div_mid1  <= DIV_MID1_RESET;
            r_cfg.div_fast2 <= DIV_FAST2_RESET;
            r_cfg.seed      <= SEED_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DIV_SLOW0: r_cfg.div_slow0 <= i_cfg_data[NOISE_COUNT_W-1:0];
                CFG_DIV_MID1:  r_cfg.div_mid1  <= i_cfg_data[NOISE_COUNT_W-1:0];
                CFG_DIV_FAST2: r_cfg.div_fast2 <= i_cfg_data[NOISE_COUNT_W-1:0];
                CFG_SEED:      r_cfg.seed      <= i_cfg_data[NOISE_SHIFT_W-1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    sng_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_kind    (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .i_cfg     (r_cfg),
        .o_updated (w_updated),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_user <= w_updated;
            r_m_data <= TDATA_W'(w_result);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: rtl/sng_checker.sv
// ----------------------------------------------------------------------------
// Sound generator port checker
// Port-level checks on the sound generator, bound to the top level.
// ----------------------------------------------------------------------------
module sng_checker
    import sng_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [TDATA_W-1:0]     m_axis_tdata,
    input  logic                   m_axis_tuser,
    input  logic                   i_cfg_valid,
    input  logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic w_in_accept;
    logic w_cfg_accept;

    assign w_in_accept  = s_axis_tvalid && s_axis_tready;
    assign w_cfg_accept = i_cfg_valid && o_cfg_ready && (i_cfg_index != '0 || i_cfg_data != '0);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // an empty output stage never holds back a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request refused with empty output stage");

    // bus writes never report an update
    a_write_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && !s_axis_tuser |=> m_axis_tvalid && !m_axis_tuser)
        else $error("bus write reported an update");

    // noise attenuation latch shows up in the next result
    a_noise_atten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && !s_axis_tuser && s_axis_tdata[7:4] == 4'hF |=>
            m_axis_tvalid && m_axis_tdata[19:16] == $past(s_axis_tdata[3:0]))
        else $error("noise attenuation not written");

    // configuration is never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready || w_cfg_accept)
        else $error("configuration write refused");

endmodule

bind square_and_noise_sound_generator sng_checker u_sng_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);
